// ===== hdl/sparse_set_counter_assert.svh =====
// Assertion macros for the sparse set counter checker.
// Included by the checker file only; needs nothing else.
`ifndef SPARSE_SET_COUNTER_ASSERT_SVH
`define SPARSE_SET_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, disabled in reset.
`define SSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sparse_set_counter: port check failed");

// Next-cycle implication, sampled on i_clk, disabled in reset.
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sparse_set_counter: port check failed");

`endif

// ===== hdl/ssc_pkg.sv =====
// Shared types and constants of the sparse set counter.
// No dependencies; imported by every other file except the assertion header.
`default_nettype none
package ssc_pkg;

    localparam int KEY_W          = 12;
    localparam int INC_W          = 32;
    localparam int SLOT_W         = 12;
    localparam int TOTAL_W        = 32;
    localparam int DEF_NUM_KEYS   = 4096;
    localparam int DEF_COUNT_BITS = 32;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   key;
        logic [INC_W-1:0]   increment;
    } t_ssc_in;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] total;
        logic               newly_added;
        logic               saturated;
    } t_ssc_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture item, read sparse map at key
        logic rd_dense; // read dense key and count at the map pointer
        logic update;   // resolve, write back, register result
    } t_ssc_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_req; // offered item is a clear
    } t_ssc_sts;

endpackage
`default_nettype wire

// ===== hdl/ssc_ctrl.sv =====
// Sequencer of the sparse set counter: idle, dense read, update.
// Depends on ssc_pkg.
`default_nettype none
module ssc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ssc_pkg::t_ssc_sts i_sts,
    output ssc_pkg::t_ssc_cmd      o_cmd,
    output logic                   o_busy
);
    import ssc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_busy  <= 1'b1;
                        r_state <= i_sts.clear_req ? S_UPDATE : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd.load     = accept;
    assign o_cmd.rd_dense = (r_state == S_READ);
    assign o_cmd.update   = (r_state == S_UPDATE);
    assign o_busy         = r_busy;

endmodule
`default_nettype wire

// ===== hdl/ssc_data.sv =====
// Datapath of the sparse set counter: sparse map, dense keys, counts,
// member count, saturating adder and result register. Depends on ssc_pkg.
`default_nettype none
module ssc_data #(
    parameter int NUM_KEYS   = ssc_pkg::DEF_NUM_KEYS,
    parameter int COUNT_BITS = ssc_pkg::DEF_COUNT_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssc_pkg::t_ssc_cmd i_cmd,
    input  wire ssc_pkg::t_ssc_in  i_in,
    output ssc_pkg::t_ssc_sts      o_sts,
    output logic                   o_done,
    output ssc_pkg::t_ssc_out      o_out
);
    import ssc_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CMP_W = ((IDX_W > KEY_W) ? IDX_W : KEY_W) + 1;
    localparam int SUM_W = ((COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W) + 1;
    localparam logic [SUM_W-1:0] CNT_MAX_EXT =
        {{(SUM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic [IDX_W-1:0]      r_sparse [NUM_KEYS];
    logic [KEY_W-1:0]      r_dense  [NUM_KEYS];
    logic [COUNT_BITS-1:0] r_counts [NUM_KEYS];

    t_ssc_in               r_item;
    logic [IDX_W-1:0]      r_map_q;
    logic [KEY_W-1:0]      r_dense_q;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic [IDX_W:0]        r_count;
    logic                  r_done;
    t_ssc_out              r_out;

    logic [CMP_W-1:0]      in_key_wide;
    logic [CMP_W-1:0]      key_wide;
    logic [IDX_W-1:0]      key_idx;
    logic                  key_ok;
    logic                  is_member;
    logic                  has_room;
    logic                  do_hit;
    logic                  do_new;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_BITS-1:0] base;
    logic [SUM_W-1:0]      sum;
    logic                  sat;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [SUM_W-1:0]      total_ext;
    logic [CMP_W-1:0]      slot_ext;

    assign o_sts.clear_req = (i_in.func == FUNC_CLEAR);

    assign in_key_wide = CMP_W'(i_in.key);
    assign key_wide = CMP_W'(r_item.key);
    assign key_idx  = key_wide[IDX_W-1:0];
    assign key_ok   = key_wide < CMP_W'(NUM_KEYS);
    assign has_room = r_count < (IDX_W+1)'(NUM_KEYS);

    // A pointer is trusted only below the member count and when the dense
    // entry points back at the key.
    always_comb begin
        is_member = 1'b0;
        if (({1'b0, r_map_q} < r_count) && (r_dense_q == r_item.key)) begin
            is_member = 1'b1;
        end
    end

    always_comb begin
        do_hit = 1'b0;
        do_new = 1'b0;
        wr_idx = r_count[IDX_W-1:0];
        base   = '0;
        if (r_item.func == FUNC_ADD && key_ok) begin
            if (is_member) begin
                do_hit = 1'b1;
                wr_idx = r_map_q;
                base   = r_cnt_q;
            end else if (has_room) begin
                do_new = 1'b1;
            end
        end
    end

    assign sum       = SUM_W'(base) + SUM_W'(r_item.increment);
    assign sat       = sum > CNT_MAX_EXT;
    assign cnt_new   = sat ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    assign total_ext = SUM_W'(cnt_new);
    assign slot_ext  = CMP_W'(wr_idx);

    // Item capture and first dependent read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in;
            r_map_q <= r_sparse[in_key_wide[IDX_W-1:0]];
        end
        if (i_cmd.rd_dense) begin
            r_dense_q <= r_dense[r_map_q];
            r_cnt_q   <= r_counts[r_map_q];
        end
    end

    // Write back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && do_new) begin
            r_sparse[key_idx] <= wr_idx;
            r_dense[wr_idx]   <= r_item.key;
        end
        if (i_cmd.update && (do_new || do_hit)) begin
            r_counts[wr_idx] <= cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cmd.update) begin
                if (r_item.func == FUNC_CLEAR) begin
                    r_count <= '0;
                end else if (do_new) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (do_hit || do_new) begin
                r_out.slot        <= slot_ext[SLOT_W-1:0];
                r_out.total       <= total_ext[TOTAL_W-1:0];
                r_out.newly_added <= do_new;
                r_out.saturated   <= sat;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule
`default_nettype wire

// ===== hdl/sparse_set_counter.sv =====
// Top level of the sparse set counter: controller plus datapath.
// Depends on ssc_pkg, ssc_ctrl and ssc_data.
//
// Usage:
//   Input channel: drive i_in and raise i_start; the item transfers at the
//   rising edge where i_start is high and o_busy is low. i_in.func selects
//   add (key plus increment) or clear (member count to zero, stores kept).
//   Result channel: o_done pulses for exactly one cycle with o_out holding
//   slot, total, newly_added and saturated. The receiver must take it then;
//   there is no way to stall the result.
//   Sequence: an add runs from transfer to o_done through a sparse map
//   read, a dense key and count read at the map pointer, then resolve and
//   write back; a clear skips the dense read. A new item can transfer in
//   the cycle o_done is high, so items do not overlap; the chained reads
//   of the three single-port memories set the pace.
//   Reset (synchronous, i_rst_n low): sequencer idle, member count zero, no
//   result pending. The memories are not swept: stale map pointers are
//   rejected by the bound and back-pointer check, so no clearing pass runs.
//   Keys at or above NUM_KEYS, and new keys on a full set, return all zero.
`default_nettype none
module sparse_set_counter #(
    parameter int NUM_KEYS   = ssc_pkg::DEF_NUM_KEYS,
    parameter int COUNT_BITS = ssc_pkg::DEF_COUNT_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire ssc_pkg::t_ssc_in i_in,
    output logic                  o_busy,
    output logic                  o_done,
    output ssc_pkg::t_ssc_out     o_out
);
    import ssc_pkg::*;

    t_ssc_cmd cmd;
    t_ssc_sts sts;

    // Sequence the item through read, read, update; a clear skips the second read.
    ssc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Hold the stores and compute the result.
    ssc_data #(
        .NUM_KEYS   (NUM_KEYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_data (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== hdl/ssc_checker.sv =====
// Port-level checker for the sparse set counter, bound to the top level.
// Depends on ssc_pkg and sparse_set_counter_assert.svh.
`default_nettype none
`include "sparse_set_counter_assert.svh"
module ssc_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ssc_pkg::t_ssc_in  i_in,
    input  wire logic              o_busy,
    input  wire logic              o_done,
    input  wire ssc_pkg::t_ssc_out o_out
);
    import ssc_pkg::*;

    logic clear_xfer;

    assign clear_xfer = i_start && !o_busy && (i_in.func == FUNC_CLEAR);

    // A transfer must make the block busy.
    `SSC_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy)
    // A result follows the end of busy, never overlaps it.
    `SSC_ASSERT_NOW(a_done_idle, o_done, !o_busy && $past(o_busy))
    // A clear reports an all-zero result, through the update state and then the done register.
    `SSC_ASSERT_NEXT(a_clear_zero, clear_xfer, ##1 (o_done && o_out == '0))
    // Results never come back to back.
    `SSC_ASSERT_NEXT(a_done_single, o_done, !o_done)

endmodule

bind sparse_set_counter ssc_checker u_ssc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_in    (i_in),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_out   (o_out)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the counting sparse set: drives add and clear commands,
// predicts slot, count, new-member and saturation flags, compares every result strobe.
// Depends on ssc_pkg and the sparse_set_counter top level only.

// Mirror of the set state plus the queue of results still owed by the block.
class set_count_board;
    bit [12:0]                 member_total;
    bit [11:0]                 key_slot   [4096];
    bit [11:0]                 slot_key   [4096];
    bit [31:0]                 slot_count [4096];
    ssc_pkg::t_ssc_out         awaited_outcomes [$];
    int                        errors;

    function new();
        member_total = '0;
        errors       = 0;
    endfunction

    // Advance the mirror by one accepted command and queue its result.
    function void note_transfer(ssc_pkg::t_ssc_in item);
        ssc_pkg::t_ssc_out outcome;
        bit [11:0]         p;
        bit [32:0]         sum;
        outcome = '0;
        if (item.func == ssc_pkg::FUNC_CLEAR) begin
            member_total = '0;
        end else begin
            p = key_slot[item.key];
            if ({1'b0, p} < member_total && slot_key[p] == item.key) begin
                sum = {1'b0, slot_count[p]} + {1'b0, item.increment};
                outcome.saturated = sum[32];
                outcome.total     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                outcome.slot      = p;
                slot_count[p]     = outcome.total;
            end else if (member_total < 13'd4096) begin
                p                   = member_total[11:0];
                member_total        = member_total + 13'd1;
                key_slot[item.key]  = p;
                slot_key[p]         = item.key;
                slot_count[p]       = item.increment;
                outcome.slot        = p;
                outcome.total       = item.increment;
                outcome.newly_added = 1'b1;
            end
        end
        awaited_outcomes.push_back(outcome);
    endfunction

    function void check_outcome(ssc_pkg::t_ssc_out got);
        ssc_pkg::t_ssc_out want;
        if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, got);
            errors++;
            return;
        end
        want = awaited_outcomes.pop_front();
        if (got.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, got %0d", $time, want.slot, got.slot);
            errors++;
        end
        if (got.total !== want.total) begin
            $display("%0t: total mismatch: expected %h, got %h", $time, want.total, got.total);
            errors++;
        end
        if (got.newly_added !== want.newly_added) begin
            $display("%0t: newly_added mismatch: expected %b, got %b",
                     $time, want.newly_added, got.newly_added);
            errors++;
        end
        if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %b, got %b",
                     $time, want.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module testbench;
    import ssc_pkg::*;

    // Cycles with neither a command transfer nor a result before the run is abandoned.
    // The slowest legal stretch is the longest sender gap, MAX_GAP, plus one add.
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_GAP      = 40;
    localparam int PHASE_ITEMS  = 430;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    t_ssc_in           i_in    = '0;
    logic              o_busy;
    logic              o_done;
    t_ssc_out          o_out;

    set_count_board    board;
    int                idle_cycles = 0;
    logic [11:0]       hot_keys [16];

    sparse_set_counter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor and watchdog. Check the result before noting a same-edge transfer:
    // the result always belongs to an older command, so the queue order holds.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                board.check_outcome(o_out);
            if (i_start && !o_busy)
                board.note_transfer(i_in);
            if (o_done || (i_start && !o_busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_ssc_in make_add(logic [11:0] key, logic [31:0] inc);
        t_ssc_in item;
        item.func      = FUNC_ADD;
        item.key       = key;
        item.increment = inc;
        return item;
    endfunction

    // Clear carries junk in the ignored fields so they are seen to be ignored.
    function automatic t_ssc_in make_clear();
        t_ssc_in item;
        item.func      = FUNC_CLEAR;
        item.key       = 12'($urandom);
        item.increment = $urandom;
        return item;
    endfunction

    function automatic logic [31:0] pick_increment();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(15));
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - 32'($urandom_range(15));
            default: return 32'h8000_0000 | $urandom;
        endcase
    endfunction

    // Mostly revisit a small pool of keys so members build up counts and saturate.
    function automatic logic [11:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return hot_keys[4'($urandom_range(15))];
        else if (r < 85)
            return 12'($urandom_range(4095));
        else
            return ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
    endfunction

    // Offer one command after an idle stretch drawn per cycle at idle_pct percent,
    // then hold it until it transfers. Called and returns on a rising edge;
    // start is left high so a following command can go back to back.
    task automatic transfer_item(input t_ssc_in item, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.awaited_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int idle_pct, input int count);
        t_ssc_in item;
        foreach (hot_keys[i])
            hot_keys[i] = 12'($urandom_range(4095));
        repeat (count) begin
            if ($urandom_range(99) < 5)
                item = make_clear();
            else
                item = make_add(pick_key(), pick_increment());
            transfer_item(item, idle_pct);
        end
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set, extreme keys and counts, saturation edges,
        // stale pointers after a clear, and back-to-back clears.
        transfer_item(make_add(12'h000, 32'h0000_0000), 38);
        transfer_item(make_add(12'hFFF, 32'hFFFF_FFFF), 38);
        transfer_item(make_add(12'hFFF, 32'h0000_0000), 38); // at maximum, no clamp
        transfer_item(make_add(12'hFFF, 32'h0000_0001), 38); // clamp by one
        transfer_item(make_add(12'h000, 32'hFFFF_FFFF), 38); // reach maximum exactly
        transfer_item(make_add(12'h000, 32'hFFFF_FFFF), 38); // clamp by a lot
        transfer_item(make_add(12'hAAA, 32'h5555_5555), 38);
        transfer_item(make_add(12'h555, 32'hAAAA_AAAA), 38);
        transfer_item(make_add(12'hAAA, 32'hAAAA_AAAA), 38); // sum lands on maximum
        transfer_item(make_clear(), 38);
        transfer_item(make_add(12'h555, 32'h0000_0005), 38); // stale pointer above count
        transfer_item(make_add(12'hAAA, 32'h0000_0007), 38);
        transfer_item(make_add(12'h123, 32'h0000_0002), 38);
        transfer_item(make_add(12'hFFF, 32'h0000_0003), 38); // stale pointer below count
        transfer_item(make_add(12'h555, 32'h0000_0001), 38);
        transfer_item(make_add(12'hFFF, 32'hFFFF_FFFF), 38);
        transfer_item(make_clear(), 0);
        transfer_item(make_clear(), 0);
        transfer_item(make_add(12'h000, 32'h0000_0001), 0);
        transfer_item(make_add(12'h000, 32'h0000_0001), 0);
        drain_results();

        // Random: sender idles 38 then 75 in a hundred, then not at all.
        run_random(38, PHASE_ITEMS);
        drain_results();
        run_random(75, PHASE_ITEMS);
        run_random(0, PHASE_ITEMS / 2);
        run_random(0, PHASE_ITEMS / 2);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.awaited_outcomes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
